// ----- hdl/lrpw_pkg.sv -----
// Shared types and constants of the line rasterizer pixel writer.
`default_nettype none
package lrpw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam int ADDR_BITS  = 26;
  localparam int COLOR_BITS = 24;
  localparam int WIDTH_BITS = 13;
  localparam int BPP_BITS   = 3;
  localparam int CHAN_BITS  = 8;
  localparam int DATA_BITS  = 32;
  localparam int PADDR_BITS = 5;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 13'd640;
  localparam logic [BPP_BITS-1:0]   BPP_RESET   = 3'd2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic {
    MODE_RGB565 = 1'b0,
    MODE_RGB888 = 1'b1
  } color_mode_e;

  typedef enum logic [2:0] {
    REG_SURFACE_WIDTH = 3'd0,
    REG_BYTES_PER_PIX = 3'd1,
    REG_COLOR_MODE    = 3'd2,
    REG_FG_RED        = 3'd3,
    REG_FG_GREEN      = 3'd4,
    REG_FG_BLUE       = 3'd5
  } reg_idx_e;

  // Stepping directions of one line.
  typedef struct packed {
    logic ymaj;
    logic yneg;
    logic xneg;
  } dir_flags_t;

endpackage
`default_nettype wire

// ----- hdl/line_rasterizer_pixel_writer.sv -----
// Top level of the Bresenham line rasterizer with framebuffer pixel output.
// Requests enter on the input channel (in_valid_i / in_stall_o). A request
// with op 0 loads a line from (x_start, y_start) to (x_end, y_end) and
// produces nothing; a request with op 1 produces the next pixel of the line
// on the output channel (out_valid_o / out_stall_i), carrying its x and y,
// its byte address (x + y * surface_width) * bytes_per_pixel in 26 bits, the
// packed foreground colour and a last flag on the line's end point. A pixel
// request with no line in progress is consumed silently, and a load while a
// line is in progress replaces it at once.
// Throughput is one request per clock when the output does not stall: the
// front end classifies a request and writes it to a two-entry queue, the
// stepper retires one queued request per cycle, and the address multiply
// runs behind it in a two-stage pipeline of the address stage and the
// output register. When the receiver stalls, the output register holds
// its pixel, the pipeline and then the queue fill, and in_stall_o rises
// once the queue is full. Reset empties the queue and the pipeline, leaves
// no line in progress and restores the register defaults (surface width 640,
// two bytes per pixel, RGB565, black). Configuration is written through the
// APB port, registers at byte addresses 0, 4, ... 20; pready is always high.
`default_nettype none
module line_rasterizer_pixel_writer #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = lrpw_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // APB configuration port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lrpw_pkg::PADDR_BITS-1:0]      paddr,
  input  wire logic [lrpw_pkg::DATA_BITS-1:0]       pwdata,
  output logic [lrpw_pkg::DATA_BITS-1:0]            prdata,
  output logic                                      pready,
  // Request channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 op_i,
  input  wire logic [COORD_BITS-1:0]                x_start_i,
  input  wire logic [COORD_BITS-1:0]                y_start_i,
  input  wire logic [COORD_BITS-1:0]                x_end_i,
  input  wire logic [COORD_BITS-1:0]                y_end_i,
  // Pixel channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [COORD_BITS-1:0]                     pixel_x_o,
  output logic [COORD_BITS-1:0]                     pixel_y_o,
  output logic [lrpw_pkg::ADDR_BITS-1:0]            byte_address_o,
  output logic [lrpw_pkg::COLOR_BITS-1:0]           color_word_o,
  output logic                                      last_o
);

  localparam int CmdBits = 6 * COORD_BITS + 6;
  localparam int WBits   = lrpw_pkg::WIDTH_BITS;
  localparam int BBits   = lrpw_pkg::BPP_BITS;
  localparam int CBits   = lrpw_pkg::CHAN_BITS;
  localparam int DBits   = lrpw_pkg::DATA_BITS;

  // Configuration registers.
  logic [WBits-1:0] surface_width_q;
  logic [BBits-1:0] bpp_q;
  logic             color_mode_q;
  logic [CBits-1:0] fg_red_q;
  logic [CBits-1:0] fg_green_q;
  logic [CBits-1:0] fg_blue_q;

  logic                 cfg_write;
  lrpw_pkg::reg_idx_e   cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = lrpw_pkg::reg_idx_e'(paddr[4:2]);

  // Writes to the two unused addresses of the index field fall through
  // the default arm and change nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surface_width_q <= lrpw_pkg::WIDTH_RESET;
      bpp_q           <= lrpw_pkg::BPP_RESET;
      color_mode_q    <= lrpw_pkg::MODE_RGB565;
      fg_red_q        <= '0;
      fg_green_q      <= '0;
      fg_blue_q       <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        lrpw_pkg::REG_SURFACE_WIDTH: surface_width_q <= pwdata[WBits-1:0];
        lrpw_pkg::REG_BYTES_PER_PIX: bpp_q           <= pwdata[BBits-1:0];
        lrpw_pkg::REG_COLOR_MODE:    color_mode_q    <= pwdata[0];
        lrpw_pkg::REG_FG_RED:        fg_red_q        <= pwdata[CBits-1:0];
        lrpw_pkg::REG_FG_GREEN:      fg_green_q      <= pwdata[CBits-1:0];
        lrpw_pkg::REG_FG_BLUE:       fg_blue_q       <= pwdata[CBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lrpw_pkg::REG_SURFACE_WIDTH: prdata = DBits'(surface_width_q);
      lrpw_pkg::REG_BYTES_PER_PIX: prdata = DBits'(bpp_q);
      lrpw_pkg::REG_COLOR_MODE:    prdata = DBits'(color_mode_q);
      lrpw_pkg::REG_FG_RED:        prdata = DBits'(fg_red_q);
      lrpw_pkg::REG_FG_GREEN:      prdata = DBits'(fg_green_q);
      lrpw_pkg::REG_FG_BLUE:       prdata = DBits'(fg_blue_q);
      default:                     prdata = '0;
    endcase
  end

  // The colour must change only while the block is idle, which the block does
  // not enforce; it drives the output directly, steady under a stall only then.
  // RGB565 is sent low byte first; RGB888 puts red in the first byte lane.
  always_comb begin
    if (lrpw_pkg::color_mode_e'(color_mode_q) == lrpw_pkg::MODE_RGB888) begin
      color_word_o = {fg_blue_q, fg_green_q, fg_red_q};
    end else begin
      color_word_o = {8'h00, fg_red_q[7:3], fg_green_q[7:2], fg_blue_q[7:3]};
    end
  end

  // Front end and queue.
  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  logic [CmdBits-1:0] q_wdata;
  logic [CmdBits-1:0] q_rdata;

  lrpw_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wdata)
  );

  lrpw_queue #(
    .WIDTH(CmdBits),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // Back end: stepper followed by the address pipeline.
  logic                  pix_valid;
  logic                  pix_ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic                  pix_last;

  lrpw_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_rdata),
    .q_pop_o     (q_pop),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_last_o  (pix_last)
  );

  lrpw_addr_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_addr_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pix_valid_i       (pix_valid),
    .pix_ready_o       (pix_ready),
    .pix_x_i           (pix_x),
    .pix_y_i           (pix_y),
    .pix_last_i        (pix_last),
    .surface_width_i   (surface_width_q),
    .bytes_per_pixel_i (bpp_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pixel_x_o         (pixel_x_o),
    .pixel_y_o         (pixel_y_o),
    .byte_address_o    (byte_address_o),
    .last_o            (last_o)
  );

endmodule
`default_nettype wire

// ----- hdl/lrpw_front.sv -----
// Front end: accepts requests, classifies them and prepares line setup values.
`default_nettype none
module lrpw_front #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF,
  localparam int ErrBits   = COORD_BITS + 2,
  localparam int CmdBits   = 6 * COORD_BITS + 6
) (
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [COORD_BITS-1:0] x_start_i,
  input  wire logic [COORD_BITS-1:0] y_start_i,
  input  wire logic [COORD_BITS-1:0] x_end_i,
  input  wire logic [COORD_BITS-1:0] y_end_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output logic [CmdBits-1:0]         q_cmd_o
);

  lrpw_pkg::dir_flags_t    flags;
  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [COORD_BITS-1:0]   major_d;
  logic [COORD_BITS-1:0]   minor_d;
  logic [COORD_BITS-1:0]   major_end;
  logic signed [ErrBits-1:0] err_init;
  logic                    is_load;

  always_comb begin
    flags.xneg = (x_end_i < x_start_i);
    flags.yneg = (y_end_i < y_start_i);
    dx = flags.xneg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    dy = flags.yneg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    // X is the major axis on a tie.
    flags.ymaj = (dx < dy);
    major_d   = flags.ymaj ? dy : dx;
    minor_d   = flags.ymaj ? dx : dy;
    major_end = flags.ymaj ? y_end_i : x_end_i;
    err_init  = $signed({2'b00, minor_d}) - $signed({3'b000, major_d[COORD_BITS-1:1]});
    is_load   = (lrpw_pkg::op_e'(op_i) == lrpw_pkg::OP_LOAD);
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_cmd_o    = {is_load, flags, x_start_i, y_start_i, major_end, dx, dy, err_init};

endmodule
`default_nettype wire

// ----- hdl/lrpw_queue.sv -----
// Small register queue that decouples the front end from the stepper.
`default_nettype none
module lrpw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrpw_pkg::QUEUE_DEPTH,
  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntBits = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q;
  logic [PtrBits-1:0] rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lrpw_stepper.sv -----
// Back end stepper: holds the line state and walks it one pixel per request.
`default_nettype none
module lrpw_stepper #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF,
  localparam int ErrBits   = COORD_BITS + 2,
  localparam int CmdBits   = 6 * COORD_BITS + 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  wire logic [CmdBits-1:0]    q_cmd_i,
  output logic                       q_pop_o,
  output logic                       pix_valid_o,
  input  wire logic                  pix_ready_i,
  output logic [COORD_BITS-1:0]      pix_x_o,
  output logic [COORD_BITS-1:0]      pix_y_o,
  output logic                       pix_last_o
);

  logic                      c_load;
  lrpw_pkg::dir_flags_t      c_flags;
  logic [COORD_BITS-1:0]     c_x0;
  logic [COORD_BITS-1:0]     c_y0;
  logic [COORD_BITS-1:0]     c_mend;
  logic [COORD_BITS-1:0]     c_dx;
  logic [COORD_BITS-1:0]     c_dy;
  logic signed [ErrBits-1:0] c_err;

  logic                      busy_q;
  lrpw_pkg::dir_flags_t      flags_q;
  logic [COORD_BITS-1:0]     cur_x_q;
  logic [COORD_BITS-1:0]     cur_y_q;
  logic [COORD_BITS-1:0]     mend_q;
  logic [COORD_BITS-1:0]     dx_q;
  logic [COORD_BITS-1:0]     dy_q;
  logic signed [ErrBits-1:0] err_q;

  logic                      is_last;
  logic                      err_pos;
  logic                      emit;
  logic [COORD_BITS-1:0]     cur_x_d;
  logic [COORD_BITS-1:0]     cur_y_d;
  logic signed [ErrBits-1:0] err_d;
  logic signed [ErrBits-1:0] minor_s;
  logic signed [ErrBits-1:0] major_s;

  assign {c_load, c_flags, c_x0, c_y0, c_mend, c_dx, c_dy, c_err} = q_cmd_i;

  always_comb begin
    is_last = ((flags_q.ymaj ? cur_y_q : cur_x_q) == mend_q);
    err_pos = (err_q > 0);
    minor_s = $signed({2'b00, flags_q.ymaj ? dx_q : dy_q});
    major_s = $signed({2'b00, flags_q.ymaj ? dy_q : dx_q});
    err_d   = err_q + minor_s - (err_pos ? major_s : '0);
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    if (flags_q.ymaj) begin
      cur_y_d = flags_q.yneg ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      if (err_pos) begin
        cur_x_d = flags_q.xneg ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
    end else begin
      cur_x_d = flags_q.xneg ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      if (err_pos) begin
        cur_y_d = flags_q.yneg ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
    end
  end

  // A step request with no line in progress is dropped without a pixel.
  assign pix_valid_o = !q_empty_i && !c_load && busy_q;
  assign emit        = pix_valid_o && pix_ready_i;
  assign q_pop_o     = !q_empty_i && (c_load || !busy_q || pix_ready_i);
  assign pix_x_o     = cur_x_q;
  assign pix_y_o     = cur_y_q;
  assign pix_last_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      flags_q <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      mend_q  <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      err_q   <= '0;
    end else if (!q_empty_i && c_load) begin
      busy_q  <= 1'b1;
      flags_q <= c_flags;
      cur_x_q <= c_x0;
      cur_y_q <= c_y0;
      mend_q  <= c_mend;
      dx_q    <= c_dx;
      dy_q    <= c_dy;
      err_q   <= c_err;
    end else if (emit) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
        err_q   <= err_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lrpw_addr_pipe.sv -----
// Two-stage byte address pipeline with the output register.
`default_nettype none
module lrpw_addr_pipe #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF,
  localparam int AddrBits  = lrpw_pkg::ADDR_BITS,
  localparam int WBits     = lrpw_pkg::WIDTH_BITS,
  localparam int BBits     = lrpw_pkg::BPP_BITS,
  localparam int SumBits   = COORD_BITS + WBits + 1,
  localparam int MulBits   = (SumBits > AddrBits) ? SumBits : AddrBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pix_valid_i,
  output logic                       pix_ready_o,
  input  wire logic [COORD_BITS-1:0] pix_x_i,
  input  wire logic [COORD_BITS-1:0] pix_y_i,
  input  wire logic                  pix_last_i,
  input  wire logic [WBits-1:0]      surface_width_i,
  input  wire logic [BBits-1:0]      bytes_per_pixel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [COORD_BITS-1:0]      pixel_x_o,
  output logic [COORD_BITS-1:0]      pixel_y_o,
  output logic [AddrBits-1:0]        byte_address_o,
  output logic                       last_o
);

  logic                    a_valid_q;
  logic [COORD_BITS-1:0]   a_x_q;
  logic [COORD_BITS-1:0]   a_y_q;
  logic                    a_last_q;
  logic [AddrBits-1:0]     a_sum_q;
  logic [MulBits-1:0]      sum_full;
  logic [AddrBits+BBits-1:0] addr_full;
  logic                    o_free;
  logic                    a_move;
  logic                    a_free;

  assign sum_full  = MulBits'(pix_y_i) * MulBits'(surface_width_i) + MulBits'(pix_x_i);
  assign addr_full = a_sum_q * bytes_per_pixel_i;

  assign o_free      = !out_valid_o || !out_stall_i;
  assign a_move      = a_valid_q && o_free;
  assign a_free      = !a_valid_q || a_move;
  assign pix_ready_o = a_free;

  always_ff @(posedge clk_i) begin
    if (pix_valid_i && a_free) begin
      a_x_q    <= pix_x_i;
      a_y_q    <= pix_y_i;
      a_last_q <= pix_last_i;
      a_sum_q  <= sum_full[AddrBits-1:0];
    end
    if (a_move) begin
      pixel_x_o      <= a_x_q;
      pixel_y_o      <= a_y_q;
      last_o         <= a_last_q;
      byte_address_o <= addr_full[AddrBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= pix_valid_i;
      end
      if (o_free) begin
        out_valid_o <= a_valid_q;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lrpw_checker.sv -----
// Port-level checker for the line rasterizer pixel writer and its bind.
`default_nettype none
module lrpw_checker #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            pready,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [COORD_BITS-1:0]           pixel_x_o,
  input wire logic [COORD_BITS-1:0]           pixel_y_o,
  input wire logic [lrpw_pkg::ADDR_BITS-1:0]  byte_address_o,
  input wire logic                            last_o
);

  // Reset leaves no pixel pending and room in the request queue.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> (!out_valid_o && !in_stall_o))
    else $error("pixel pending or request stall during reset");

  a_pready_high: assert property (@(posedge clk_i) pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled pixel withdrawn");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(pixel_x_o) && $stable(pixel_y_o) && $stable(byte_address_o) &&
       $stable(last_o)))
    else $error("stalled pixel changed");

endmodule

bind line_rasterizer_pixel_writer lrpw_checker #(
  .COORD_BITS(COORD_BITS)
) u_lrpw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_x_o      (pixel_x_o),
  .pixel_y_o      (pixel_y_o),
  .byte_address_o (byte_address_o),
  .last_o         (last_o)
);
`default_nettype wire
